>>> sv/gsbc_pkg.sv
// ----------------------------------------------------------------------------
// gsbc_pkg: shared types and constants for the stick and button conditioner
// Holds the controller states, the command and status structs and the
// fixed constants of the stick arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package gsbc_pkg;

    // field widths
    localparam int AxisW    = 8;
    localparam int BtnW     = 16;
    localparam int DzW      = 7;
    localparam int AdjW     = 9;
    localparam int MagW     = 8;
    localparam int SqW      = 15;
    localparam int SumW     = 16;
    localparam int QuoW     = 31;
    localparam int RadW     = 32;
    localparam int RootW    = 16;
    localparam int OutAxisW = 16;
    localparam int LenW     = 15;

    // stick constants
    localparam logic [SumW-1:0] MaxMagSq   = 16'd4096;
    localparam logic [LenW-1:0] MaxMagQ    = 15'd16384;
    localparam logic [DzW-1:0]  OffsetSub  = 7'd2;
    localparam logic [DzW-1:0]  DzReset    = 7'd8;

    // iteration counts
    localparam int DivSteps  = QuoW;
    localparam int SqrtSteps = RadW / 2;
    localparam int CntW      = $clog2(DivSteps);

    // configuration register indexes
    localparam logic CfgDzStandard  = 1'b0;
    localparam logic CfgDzAlternate = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_PREP,
        ST_DIV,
        ST_ROOT_LOAD,
        ST_ROOT,
        ST_DONE
    } gsbc_state_t;

    typedef struct packed {
        logic load_item;
        logic calc_sum;
        logic div_load;
        logic div_step;
        logic sqrt_load_axes;
        logic sqrt_load_len;
        logic sqrt_step;
        logic out_load;
    } gsbc_cmd_t;

    typedef struct packed {
        logic scaled;
        logic out_free;
    } gsbc_status_t;

endpackage

`default_nettype wire

>>> sv/gsbc_div_lane.sv
// ----------------------------------------------------------------------------
// gsbc_div_lane: radix-2 restoring divider lane
// Computes floor(num * 2^30 / den) for num <= den, one quotient bit a cycle while step is high.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbc_div_lane
    import gsbc_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            load,
    input  wire logic            step,
    input  wire logic [SqW-1:0]  num,
    input  wire logic [SumW-1:0] den,
    output logic      [QuoW-1:0] quo
);

    logic [SumW:0]   rem_reg;
    logic [SumW:0]   rem_next;
    logic [QuoW-1:0] quo_reg;
    logic [QuoW-1:0] quo_next;
    logic [SumW:0]   diff;
    logic            ge;

    // compare and subtract, then shift the partial remainder
    always_comb
    begin
        ge       = (rem_reg >= {1'b0, den});
        diff     = rem_reg - {1'b0, den};
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (load)
        begin
            rem_next = {2'b00, num};
            quo_next = '0;
        end
        else if (step)
        begin
            rem_next = ge ? {diff[SumW-1:0], 1'b0} : {rem_reg[SumW-1:0], 1'b0};
            quo_next = {quo_reg[QuoW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quo = quo_reg;

endmodule

`default_nettype wire

>>> sv/gsbc_sqrt_lane.sv
// ----------------------------------------------------------------------------
// gsbc_sqrt_lane: digit-by-digit integer square root lane
// Two radicand bits a cycle while step is high; gives the root of radicand / 4 rounded to nearest.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbc_sqrt_lane
    import gsbc_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             load,
    input  wire logic             step,
    input  wire logic [RadW-1:0]  rad,
    output logic      [RootW-1:0] rounded
);

    logic [RadW-1:0]  rad_reg;
    logic [RadW-1:0]  rad_next;
    logic [RootW+1:0] rem_reg;
    logic [RootW+1:0] rem_next;
    logic [RootW-1:0] root_reg;
    logic [RootW-1:0] root_next;
    logic [RootW+3:0] rem_sh;
    logic [RootW+3:0] trial;
    logic [RootW+3:0] sub;
    logic [RootW:0]   root_inc;
    logic             ge;

    // one root bit per step
    always_comb
    begin
        rem_sh    = {rem_reg, rad_reg[RadW-1:RadW-2]};
        trial     = {2'b00, root_reg, 2'b01};
        ge        = (rem_sh >= trial);
        sub       = rem_sh - trial;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (load)
        begin
            rad_next  = rad;
            rem_next  = '0;
            root_next = '0;
        end
        else if (step)
        begin
            rad_next  = {rad_reg[RadW-3:0], 2'b00};
            rem_next  = ge ? sub[RootW+1:0] : rem_sh[RootW+1:0];
            root_next = {root_reg[RootW-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    // half the full-precision root, rounded up on an odd root
    assign root_inc = {1'b0, root_reg} + {{RootW{1'b0}}, 1'b1};
    assign rounded  = root_inc[RootW:1];

endmodule

`default_nettype wire

>>> sv/gsbc_ctrl.sv
// ----------------------------------------------------------------------------
// gsbc_ctrl: sequencer for the stick and button conditioner
// Steps one item through sum, divide (clamped items only), root and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbc_ctrl
    import gsbc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire gsbc_status_t stat,
    output gsbc_cmd_t         cmd
);

    gsbc_state_t     state_reg;
    gsbc_state_t     state_next;
    logic [CntW-1:0] cnt_reg;
    logic [CntW-1:0] cnt_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_SUM;
                end
            end
            ST_SUM:
            begin
                cmd.calc_sum = 1'b1;
                state_next   = ST_PREP;
            end
            ST_PREP:
            begin
                cnt_next = '0;
                if (stat.scaled)
                begin
                    cmd.div_load = 1'b1;
                    state_next   = ST_DIV;
                end
                else
                begin
                    cmd.sqrt_load_len = 1'b1;
                    state_next        = ST_ROOT;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(DivSteps - 1))
                begin
                    state_next = ST_ROOT_LOAD;
                end
            end
            ST_ROOT_LOAD:
            begin
                cmd.sqrt_load_axes = 1'b1;
                cnt_next           = '0;
                state_next         = ST_ROOT;
            end
            ST_ROOT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == CntW'(SqrtSteps - 1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/gsbc_datapath.sv
// ----------------------------------------------------------------------------
// gsbc_datapath: button masking, deadzone, radial clamp and result register
// Holds the deadzone registers, button state, divider and root lanes.
// ----------------------------------------------------------------------------
`default_nettype none

module gsbc_datapath
    import gsbc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire gsbc_cmd_t            cmd,
    output gsbc_status_t              stat,
    input  wire logic                 cfg_write,
    input  wire logic                 cfg_index,
    input  wire logic [DzW-1:0]       cfg_data,
    input  wire logic signed [AxisW-1:0] raw_stick_x,
    input  wire logic signed [AxisW-1:0] raw_stick_y,
    input  wire logic [BtnW-1:0]      raw_buttons,
    input  wire logic                 alternate_type,
    input  wire logic                 lock_request,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [BtnW-1:0]           held_buttons,
    output logic [BtnW-1:0]           pressed_buttons,
    output logic [BtnW-1:0]           released_buttons,
    output logic signed [OutAxisW-1:0] stick_x_adj,
    output logic signed [OutAxisW-1:0] stick_y_adj,
    output logic [LenW-1:0]           stick_length
);

    // deadzone adjust of one axis: pulled toward centre by dz - 2
    function automatic logic signed [AdjW-1:0] adjust_axis(
        input logic signed [AxisW-1:0] raw,
        input logic [DzW-1:0]          dz
    );
        logic signed [AdjW:0] r;
        logic signed [AdjW:0] d;
        logic signed [AdjW:0] off;
        logic signed [AdjW:0] v;
        r   = (AdjW+1)'(raw);
        d   = $signed({{(AdjW+1-DzW){1'b0}}, dz});
        off = d - $signed({{(AdjW+1-DzW){1'b0}}, OffsetSub});
        v   = '0;
        if (r <= -d)
        begin
            v = r + off;
        end
        if (r >= d)
        begin
            v = r - off;
        end
        return v[AdjW-1:0];
    endfunction

    logic [DzW-1:0]        dz_std_reg;
    logic [DzW-1:0]        dz_alt_reg;
    logic [BtnW-1:0]       prev_held_reg;
    logic [BtnW-1:0]       lock_mask_reg;
    logic [BtnW-1:0]       held_reg;
    logic [BtnW-1:0]       pressed_reg;
    logic [BtnW-1:0]       released_reg;
    logic signed [AdjW-1:0] sx_reg;
    logic signed [AdjW-1:0] sy_reg;
    logic [SqW-1:0]        sq_x_reg;
    logic [SqW-1:0]        sq_y_reg;
    logic [SumW-1:0]       sum_reg;
    logic                  out_valid_reg;
    logic [BtnW-1:0]       out_held_reg;
    logic [BtnW-1:0]       out_pressed_reg;
    logic [BtnW-1:0]       out_released_reg;
    logic [OutAxisW-1:0]   out_x_reg;
    logic [OutAxisW-1:0]   out_y_reg;
    logic [LenW-1:0]       out_len_reg;

    logic [DzW-1:0]        dz_sel;
    logic [BtnW-1:0]       lock_next;
    logic [BtnW-1:0]       held_next;
    logic [MagW-1:0]       mag_x;
    logic [MagW-1:0]       mag_y;
    logic [2*MagW-1:0]     sq_x_full;
    logic [2*MagW-1:0]     sq_y_full;
    logic [QuoW-1:0]       quo_x;
    logic [QuoW-1:0]       quo_y;
    logic [RadW-1:0]       rad_x;
    logic [RadW-1:0]       rad_y;
    logic [RootW-1:0]      root_x;
    logic [RootW-1:0]      root_y;
    logic [OutAxisW-1:0]   x_result;
    logic [OutAxisW-1:0]   y_result;
    logic [LenW-1:0]       len_result;
    logic [AdjW-1:0]       neg_sx;
    logic [AdjW-1:0]       neg_sy;

    // deadzone registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dz_std_reg <= DzReset;
            dz_alt_reg <= DzReset;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CfgDzStandard:  dz_std_reg <= cfg_data;
                CfgDzAlternate: dz_alt_reg <= cfg_data;
                default:        dz_std_reg <= dz_std_reg;
            endcase
        end
    end

    // button lock and edge detect
    assign lock_next = (lock_request ? raw_buttons : lock_mask_reg) & raw_buttons;
    assign held_next = raw_buttons & ~lock_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_held_reg <= '0;
            lock_mask_reg <= '0;
        end
        else if (cmd.load_item)
        begin
            prev_held_reg <= held_next;
            lock_mask_reg <= lock_next;
        end
    end

    // item capture
    assign dz_sel = alternate_type ? dz_alt_reg : dz_std_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            held_reg     <= held_next;
            pressed_reg  <= ~prev_held_reg & held_next;
            released_reg <= ~held_next & prev_held_reg;
            sx_reg       <= adjust_axis(raw_stick_x, dz_sel);
            sy_reg       <= adjust_axis(raw_stick_y, dz_sel);
        end
    end

    // squared length
    assign neg_sx    = AdjW'(0) - sx_reg;
    assign neg_sy    = AdjW'(0) - sy_reg;
    assign mag_x     = sx_reg[AdjW-1] ? neg_sx[MagW-1:0] : sx_reg[MagW-1:0];
    assign mag_y     = sy_reg[AdjW-1] ? neg_sy[MagW-1:0] : sy_reg[MagW-1:0];
    assign sq_x_full = mag_x * mag_x;
    assign sq_y_full = mag_y * mag_y;

    always_ff @(posedge clk)
    begin
        if (cmd.calc_sum)
        begin
            sq_x_reg <= sq_x_full[SqW-1:0];
            sq_y_reg <= sq_y_full[SqW-1:0];
            sum_reg  <= SumW'(sq_x_full) + SumW'(sq_y_full);
        end
    end

    assign stat.scaled = (sum_reg > MaxMagSq);

    // per-axis ratio m^2 * 2^30 / s
    gsbc_div_lane u_div_x (
        .clk  (clk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (sq_x_reg),
        .den  (sum_reg),
        .quo  (quo_x)
    );

    gsbc_div_lane u_div_y (
        .clk  (clk),
        .load (cmd.div_load),
        .step (cmd.div_step),
        .num  (sq_y_reg),
        .den  (sum_reg),
        .quo  (quo_y)
    );

    // x lane also serves the length root s * 2^18
    assign rad_x = cmd.sqrt_load_len ? {sum_reg[13:0], 18'b0} : {1'b0, quo_x};
    assign rad_y = {1'b0, quo_y};

    gsbc_sqrt_lane u_sqrt_x (
        .clk     (clk),
        .load    (cmd.sqrt_load_axes | cmd.sqrt_load_len),
        .step    (cmd.sqrt_step),
        .rad     (rad_x),
        .rounded (root_x)
    );

    gsbc_sqrt_lane u_sqrt_y (
        .clk     (clk),
        .load    (cmd.sqrt_load_axes),
        .step    (cmd.sqrt_step),
        .rad     (rad_y),
        .rounded (root_y)
    );

    // result select: clamped radial scale or plain Q7.8
    always_comb
    begin
        if (stat.scaled)
        begin
            x_result   = sx_reg[AdjW-1] ? (OutAxisW'(0) - root_x) : root_x;
            y_result   = sy_reg[AdjW-1] ? (OutAxisW'(0) - root_y) : root_y;
            len_result = MaxMagQ;
        end
        else
        begin
            x_result   = {sx_reg[7:0], 8'b0};
            y_result   = {sy_reg[7:0], 8'b0};
            len_result = root_x[LenW-1:0];
        end
    end

    // output register
    assign stat.out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_held_reg     <= held_reg;
            out_pressed_reg  <= pressed_reg;
            out_released_reg <= released_reg;
            out_x_reg        <= x_result;
            out_y_reg        <= y_result;
            out_len_reg      <= len_result;
        end
    end

    assign out_valid        = out_valid_reg;
    assign held_buttons     = out_held_reg;
    assign pressed_buttons  = out_pressed_reg;
    assign released_buttons = out_released_reg;
    assign stick_x_adj      = $signed(out_x_reg);
    assign stick_y_adj      = $signed(out_y_reg);
    assign stick_length     = out_len_reg;

endmodule

`default_nettype wire

>>> sv/gamepad_stick_button_conditioner_unit.sv
// ----------------------------------------------------------------------------
// gamepad_stick_button_conditioner_unit: controller poll conditioner
// Button lock and edge detect, stick deadzone and radial clamp to 64.0.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel takes one controller poll per item (raw stick x/y,
//   button bits, controller type, lock request); in_stall is high while an
//   item is in work. The output channel gives one result per item from an
//   output register, so a new item is taken while a result still waits.
//   An item whose stick vector stays within length 64 passes through sum,
//   prep, root and done; one that is clamped also passes the radix-2
//   divider before the root. A new item is taken only once the sequencer
//   has loaded the last result and gone back to idle.
//   When out_stall holds a result, a finished item waits in the sequencer
//   and no further item is taken until the result register frees.
//   Reset clears button history, the lock mask and out_valid, and sets both
//   deadzones to 8. The user must write deadzones through cfg_write /
//   cfg_index / cfg_data only while no item is in work; nothing checks it.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_stick_button_conditioner_unit
    import gsbc_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_index,
    input  wire logic [DzW-1:0]          cfg_data,
    input  wire logic                    in_valid,
    output logic                         in_stall,
    input  wire logic signed [AxisW-1:0] raw_stick_x,
    input  wire logic signed [AxisW-1:0] raw_stick_y,
    input  wire logic [BtnW-1:0]         raw_buttons,
    input  wire logic                    alternate_type,
    input  wire logic                    lock_request,
    output logic                         out_valid,
    input  wire logic                    out_stall,
    output logic [BtnW-1:0]              held_buttons,
    output logic [BtnW-1:0]              pressed_buttons,
    output logic [BtnW-1:0]              released_buttons,
    output logic signed [OutAxisW-1:0]   stick_x_adj,
    output logic signed [OutAxisW-1:0]   stick_y_adj,
    output logic [LenW-1:0]              stick_length
);

    gsbc_cmd_t    cmd;
    gsbc_status_t stat;

    // sequencer
    gsbc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // datapath
    gsbc_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_write        (cfg_write),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .raw_stick_x      (raw_stick_x),
        .raw_stick_y      (raw_stick_y),
        .raw_buttons      (raw_buttons),
        .alternate_type   (alternate_type),
        .lock_request     (lock_request),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .held_buttons     (held_buttons),
        .pressed_buttons  (pressed_buttons),
        .released_buttons (released_buttons),
        .stick_x_adj      (stick_x_adj),
        .stick_y_adj      (stick_y_adj),
        .stick_length     (stick_length)
    );

    // an accepted item blocks the next one
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("item accepted while previous item in work");

    // result register is loaded only when free
    a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid || !out_stall))
        else $error("result overwritten before taken");

    // a load always presents a result
    a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> out_valid)
        else $error("result load without out_valid");

    // length never exceeds 64.0
    a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (stick_length <= MaxMagQ))
        else $error("stick length above clamp");

endmodule

`default_nettype wire
